>>> rtl/ifrt_pkg.sv
`timescale 1ns / 1ps
package ifrt_pkg;
  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_COPY      = 3'd1;
  localparam logic [2:0] ST_NO_SLOT   = 3'd2;
  localparam logic [2:0] ST_LIST_FULL = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [16:0] DGRAM_LIMIT = 17'd65536;

  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] size;
    logic        more;
    logic [15:0] handle;
    logic [7:0]  link;
    logic [7:0]  tos;
  } frag_t;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dest;
    logic [7:0]  proto;
    logic [15:0] ident;
  } key_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] handle;
    logic [15:0] copy_dest;
    logic [15:0] copy_len;
    logic [16:0] total;
    logic [31:0] src;
    logic [31:0] dest;
    logic [7:0]  proto;
    logic [7:0]  link;
    logic [7:0]  tos;
    logic        last;
  } result_t;
endpackage

>>> rtl/ifrt_frag_ram.sv
`timescale 1ns / 1ps
module ifrt_frag_ram
  import ifrt_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  frag_t         wdata,
  input  logic [AW-1:0] raddr,
  output frag_t         rdata
);
  frag_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/ip_fragment_reassembly_tracker_top.sv
`timescale 1ns / 1ps
// sequence: key scan over the slots up to the match (every slot with no match), offset
// search over the entries passed, shift of each moved entry, insert, then a completion
// walk over the entries read; a single result or each copy command is registered
// throughput: one request at a time, each copy command leaves once the one before it is taken,
// the next request is accepted once the last result has been taken
// rst clears slot valid bits and counts; fragment and key memories are not cleared
module ip_fragment_reassembly_tracker_top
  import ifrt_pkg::*;
#(
  parameter int DGRAM_SLOTS = 8,
  parameter int FRAGS_PER_DGRAM = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // src_addr, dest_addr, proto, ident, frag_offset, frag_size,
  // more_fragments, link_id, tos, buf_handle, zero pad
  input  logic [159:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, buf_handle_res, copy_dest, copy_len, total_size, src_out,
  // dest_out, proto_out, link_out, tos_out, zero pad
  output logic [159:0] m_tdata,
  output logic         m_tlast
);
  localparam int SW = (DGRAM_SLOTS > 1) ? $clog2(DGRAM_SLOTS) : 1;
  localparam int FW = $clog2(FRAGS_PER_DGRAM);
  localparam int CW = FW + 1;
  localparam int AW = SW + FW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(DGRAM_SLOTS - 1);
  localparam logic [CW-1:0] MAX_FRAGS = CW'(FRAGS_PER_DGRAM);

  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_CMP = 4'd2, S_OPEN = 4'd3,
    S_FIND = 4'd4, S_FINDW = 4'd5, S_SHR = 4'd6, S_SHW = 4'd7, S_INS = 4'd8,
    S_WALK = 4'd9, S_WALKW = 4'd10, S_EMITR = 4'd11, S_EMITW = 4'd12,
    S_ONE = 4'd13;

  logic [3:0] state;
  logic [DGRAM_SLOTS-1:0] slot_valid;
  logic [CW-1:0] slot_count [DGRAM_SLOTS];
  key_t slot_key [DGRAM_SLOTS];
  key_t key_rd;

  key_t key;
  frag_t frag;
  logic [SW-1:0] sidx, slot;
  logic have_free;
  logic [SW-1:0] free_slot;
  logic [CW-1:0] cnt, k, pos, last_k;
  logic [16:0] prev_end;
  logic [16:0] total;
  logic [7:0] last_link, last_tos;
  logic [2:0] one_status;

  logic we;
  logic [AW-1:0] waddr, raddr;
  frag_t wdata, rdata;

  ifrt_frag_ram #(.DEPTH(DGRAM_SLOTS * FRAGS_PER_DGRAM), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // key store: synchronous read
  always_ff @(posedge clk) begin
    if (state == S_OPEN) slot_key[slot] <= key;
    key_rd <= slot_key[sidx];
  end

  function automatic logic [AW-1:0] addr(input logic [SW-1:0] s, input logic [CW-1:0] i);
    addr = AW'(s * FRAGS_PER_DGRAM) + AW'(i[FW-1:0]);
  endfunction

  always_comb begin
    we = 1'b0;
    waddr = addr(slot, k);
    wdata = rdata;
    raddr = addr(slot, k);
    unique case (state)
      S_SHR: raddr = addr(slot, k - CW'(1));
      S_SHW: we = 1'b1;
      S_INS: begin
        we = 1'b1;
        waddr = addr(slot, pos);
        wdata = frag;
      end
      default: ;
    endcase
  end

  logic [16:0] fend, room;
  logic [15:0] len_clip;
  assign fend = {1'b0, rdata.offset} + {1'b0, rdata.size};
  assign room = (total > {1'b0, rdata.offset}) ? total - {1'b0, rdata.offset} : 17'd0;
  assign len_clip = ({1'b0, rdata.size} > room) ? room[15:0] : rdata.size;

  logic out_free, out_load;
  result_t res, res_next;
  assign s_tready = (state == S_IDLE) && !m_tvalid;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free && (state == S_ONE || state == S_EMITW);

  always_comb begin
    res_next = '0;
    res_next.last = 1'b1;
    if (state == S_ONE) begin
      res_next.status = one_status;
    end else begin
      res_next.status = ST_COPY;
      res_next.handle = rdata.handle;
      res_next.copy_dest = rdata.offset;
      res_next.copy_len = len_clip;
      res_next.total = total;
      res_next.src = key.src;
      res_next.dest = key.dest;
      res_next.proto = key.proto;
      res_next.link = last_link;
      res_next.tos = last_tos;
      res_next.last = (k == last_k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (out_load) res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      for (int i = 0; i < DGRAM_SLOTS; i++) slot_count[i] <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          key.src <= s_tdata[31:0];
          key.dest <= s_tdata[63:32];
          key.proto <= s_tdata[71:64];
          key.ident <= s_tdata[87:72];
          frag.offset <= s_tdata[103:88];
          frag.size <= s_tdata[119:104];
          frag.more <= s_tdata[120];
          frag.link <= s_tdata[128:121];
          frag.tos <= s_tdata[136:129];
          frag.handle <= s_tdata[152:137];
          sidx <= '0;
          have_free <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: state <= S_CMP;
        S_CMP: begin
          if (slot_valid[sidx] && key_rd == key) begin
            slot <= sidx;
            if (slot_count[sidx] >= MAX_FRAGS) begin
              one_status <= ST_LIST_FULL;
              state <= S_ONE;
            end else begin
              cnt <= slot_count[sidx];
              k <= '0;
              state <= S_FIND;
            end
          end else if (sidx != LAST_SLOT) begin
            if (!slot_valid[sidx] && !have_free) begin
              have_free <= 1'b1;
              free_slot <= sidx;
            end
            sidx <= sidx + SW'(1);
            state <= S_SCAN;
          end else if (have_free) begin
            slot <= free_slot;
            state <= S_OPEN;
          end else if (!slot_valid[sidx]) begin
            slot <= sidx;
            state <= S_OPEN;
          end else begin
            one_status <= ST_NO_SLOT;
            state <= S_ONE;
          end
        end
        S_OPEN: begin
          slot_valid[slot] <= 1'b1;
          slot_count[slot] <= '0;
          cnt <= '0;
          k <= '0;
          state <= S_FIND;
        end
        S_FIND: begin
          if (k == cnt) begin
            pos <= k;
            state <= S_INS;
          end else begin
            state <= S_FINDW;
          end
        end
        S_FINDW: begin
          // insert before the first entry with an equal or larger offset
          if (rdata.offset >= frag.offset) begin
            pos <= k;
            k <= cnt;
            state <= S_SHR;
          end else begin
            k <= k + CW'(1);
            state <= S_FIND;
          end
        end
        S_SHR: state <= S_SHW;
        S_SHW: begin
          k <= k - CW'(1);
          state <= (k - CW'(1) == pos) ? S_INS : S_SHR;
        end
        S_INS: begin
          cnt <= cnt + CW'(1);
          slot_count[slot] <= cnt + CW'(1);
          k <= '0;
          state <= S_WALK;
        end
        S_WALK: state <= S_WALKW;
        S_WALKW: begin
          if ((k == '0 && rdata.offset != 16'd0) ||
              (k != '0 && {1'b0, rdata.offset} > prev_end)) begin
            one_status <= ST_QUEUED;
            state <= S_ONE;
          end else if (!rdata.more) begin
            last_k <= k;
            total <= fend;
            last_link <= rdata.link;
            last_tos <= rdata.tos;
            slot_valid[slot] <= 1'b0;
            slot_count[slot] <= '0;
            if (fend > DGRAM_LIMIT) begin
              one_status <= ST_TOO_LARGE;
              state <= S_ONE;
            end else begin
              k <= '0;
              state <= S_EMITR;
            end
          end else if (k + CW'(1) >= cnt) begin
            one_status <= ST_QUEUED;
            state <= S_ONE;
          end else begin
            prev_end <= fend;
            k <= k + CW'(1);
            state <= S_WALK;
          end
        end
        S_EMITR: state <= S_EMITW;
        S_EMITW: if (out_free) begin
          if (k == last_k) begin
            state <= S_IDLE;
          end else begin
            k <= k + CW'(1);
            state <= S_EMITR;
          end
        end
        S_ONE: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {4'b0, res.tos, res.link, res.proto, res.dest, res.src, res.total,
                    res.copy_len, res.copy_dest, res.handle, res.status};
  assign m_tlast = res.last;
endmodule
